// ----- hw/rtl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator: command and
// status codes, register indexes and the command and response records.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAX_FRAMES_DEF = 1024;
  localparam int WORD_BITS      = 64;
  localparam int COUNT_BITS     = 10;
  localparam int FRAME_SHIFT    = 12;
  localparam int ADDR_BITS      = 32;
  localparam int CFG_BITS       = 32;
  localparam int FRAMES_BITS    = 11;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // command codes
  localparam logic [2:0] CMD_ALLOC = 3'd0;
  localparam logic [2:0] CMD_FREE  = 3'd1;
  localparam logic [2:0] CMD_MARK  = 3'd2;
  localparam logic [2:0] CMD_INC   = 3'd3;
  localparam logic [2:0] CMD_DEC   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NONE_FREE = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_MISALIGN  = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;

  // configuration register indexes
  localparam logic REG_REGION_BASE   = 1'b0;
  localparam logic REG_REGION_FRAMES = 1'b1;

  typedef struct packed {
    logic [2:0]           command;
    logic [ADDR_BITS-1:0] frame_address;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [ADDR_BITS-1:0]  result_address;
    logic [COUNT_BITS-1:0] ref_count;
  } rsp_item_t;

endpackage

// ----- hw/rtl/bitmap_frame_allocator_refcount_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_refcount_top
// Page frame allocator: first-fit allocation bitmap plus a reference
// counter per 4 KiB frame, both held in synchronous memories.
//
// Usage: program region_base (index 0) and region_frames (index 1) on the
// cfg port while idle, then send commands on cmd (valid/stall). Each command
// gives exactly one response on rsp (valid/stall), one command at a time.
// Steps from accept to response: an address error, an undefined command or
// allocate in an empty region goes from check straight to done; free, mark,
// increment and decrement pass check, issue, modify and done; allocate passes
// check, a scan of N bitmap words one per cycle (at most 16 with the default
// MAX_FRAMES) and done. The next command is accepted in the idle state that
// follows the load of the response.
// After reset a clearing pass writes zero to every counter and bitmap word,
// one entry per cycle, over MAX_FRAMES entries (1024 by default); cmd_stall stays
// high during it. A stalled response holds until taken; the next command can
// be accepted meanwhile and then waits in its last step for the output reg.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_refcount_top #(
  parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [bfa_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  bfa_pkg::cmd_item_t               cmd,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output bfa_pkg::rsp_item_t               rsp
);

  localparam int WB        = bfa_pkg::WORD_BITS;
  localparam int BIT_W     = $clog2(WB);
  localparam int NUM_WORDS = (MAX_FRAMES + WB - 1) / WB;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int FRAME_W   = $clog2(MAX_FRAMES);
  localparam int CB        = bfa_pkg::COUNT_BITS;
  localparam int AB        = bfa_pkg::ADDR_BITS;
  localparam int FS        = bfa_pkg::FRAME_SHIFT;
  localparam int FB        = bfa_pkg::FRAMES_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_ISSUE, S_MODIFY, S_SCAN, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [AB-FS-1:0] base_page;
  logic [FB-1:0]    region_frames;
  logic [FB-1:0]    limit;

  // command registers
  bfa_pkg::cmd_item_t cur;
  logic [FRAME_W-1:0] fi;
  logic [WORD_AW-1:0] fi_word;
  logic [BIT_W-1:0]   fi_bit;

  // check logic
  logic [AB-1:0]    base_addr;
  logic [AB-1:0]    diff;
  logic [AB-FS-1:0] diff_page;

  // scan
  logic [WORD_AW-1:0] scan_word;
  logic [WORD_AW-1:0] eval_word;
  logic               eval_vld;
  logic [WORD_AW-1:0] last_word;
  logic [WB-1:0]      valid_mask;
  logic [WB-1:0]      free_bits;
  logic               hit;
  logic [BIT_W-1:0]   hit_bit;
  logic [AB-1:0]      alloc_addr;

  // clearing pass
  logic [FRAME_W-1:0] clr_cnt;

  // memories
  logic [WB-1:0]      bitmap_mem [NUM_WORDS];
  logic [CB-1:0]      ref_mem    [MAX_FRAMES];
  logic               bm_we;
  logic [WORD_AW-1:0] bm_waddr;
  logic [WORD_AW-1:0] bm_raddr;
  logic [WB-1:0]      bm_wdata;
  logic [WB-1:0]      bm_rdata;
  logic               ref_we;
  logic [FRAME_W-1:0] ref_waddr;
  logic [CB-1:0]      ref_wdata;
  logic [CB-1:0]      ref_rdata;
  logic [CB-1:0]      ref_new;

  // result
  logic [2:0]    res_status;
  logic [AB-1:0] res_addr;
  logic [CB-1:0] res_count;

  assign cmd_stall = (state != S_IDLE);

  // frame count limited to the memory size
  assign limit = (32'(region_frames) > 32'(MAX_FRAMES)) ? FB'(MAX_FRAMES) : region_frames;

  assign base_addr = {base_page, {FS{1'b0}}};
  assign diff      = cur.frame_address - base_addr;
  assign diff_page = diff[AB-1:FS];

  // free bits of the word being evaluated, only frames below the limit
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      valid_mask[b] = (eval_word != last_word) || (limit[BIT_W-1:0] == '0) ||
                      (BIT_W'(b) < limit[BIT_W-1:0]);
    end
    free_bits = ~bm_rdata & valid_mask;
  end

  // lowest free bit
  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit     = 1'b1;
        hit_bit = BIT_W'(b);
      end
    end
  end

  assign alloc_addr = base_addr + (AB'({eval_word, hit_bit}) << FS);

  // saturating counter update
  always_comb begin
    ref_new = ref_rdata;
    if (cur.command == bfa_pkg::CMD_INC) begin
      if (ref_rdata != bfa_pkg::COUNT_MAX) begin
        ref_new = ref_rdata + CB'(1);
      end
    end else if (ref_rdata != '0) begin
      ref_new = ref_rdata - CB'(1);
    end
  end

  // memory write enables, write addresses and data, and read address
  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = fi_word;
    bm_wdata  = bm_rdata;
    ref_we    = 1'b0;
    ref_waddr = fi;
    ref_wdata = ref_new;
    bm_raddr  = (state == S_SCAN) ? scan_word : fi_word;
    unique case (state)
      S_CLEAR: begin
        bm_we     = (32'(clr_cnt) < NUM_WORDS);
        bm_waddr  = WORD_AW'(clr_cnt);
        bm_wdata  = '0;
        ref_we    = 1'b1;
        ref_waddr = clr_cnt;
        ref_wdata = '0;
      end
      S_MODIFY: begin
        case (cur.command)
          bfa_pkg::CMD_FREE: begin
            bm_we              = bm_rdata[fi_bit];
            bm_wdata[fi_bit]   = 1'b0;
          end
          bfa_pkg::CMD_MARK: begin
            bm_we              = 1'b1;
            bm_wdata[fi_bit]   = 1'b1;
          end
          default: begin
            ref_we = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        bm_we             = eval_vld && hit;
        bm_waddr          = eval_word;
        bm_wdata[hit_bit] = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bitmap_mem[bm_waddr] <= bm_wdata;
    end
    bm_rdata <= bitmap_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    ref_rdata <= ref_mem[fi];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_page     <= '0;
      region_frames <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bfa_pkg::REG_REGION_BASE:   base_page     <= cfg_data[AB-1:FS];
        bfa_pkg::REG_REGION_FRAMES: region_frames <= cfg_data[FB-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
      eval_vld  <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + FRAME_W'(1);
          if (clr_cnt == FRAME_W'(MAX_FRAMES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_addr   <= '0;
          res_count  <= '0;
          fi         <= diff_page[FRAME_W-1:0];
          fi_word    <= WORD_AW'(diff_page[FRAME_W-1:0] >> BIT_W);
          fi_bit     <= diff_page[BIT_W-1:0];
          unique case (cur.command) inside
            bfa_pkg::CMD_ALLOC: begin
              if (limit == '0) begin
                res_status <= bfa_pkg::ST_NONE_FREE;
                state      <= S_DONE;
              end else begin
                res_status <= bfa_pkg::ST_OK;
                scan_word  <= '0;
                eval_vld   <= 1'b0;
                last_word  <= WORD_AW'((limit - FB'(1)) >> BIT_W);
                state      <= S_SCAN;
              end
            end
            bfa_pkg::CMD_FREE, bfa_pkg::CMD_MARK, bfa_pkg::CMD_INC,
            bfa_pkg::CMD_DEC: begin
              if (cur.frame_address < base_addr ||
                  diff_page >= (AB-FS)'(limit)) begin
                res_status <= bfa_pkg::ST_RANGE;
                state      <= S_DONE;
              end else if (cur.frame_address[FS-1:0] != '0) begin
                res_status <= bfa_pkg::ST_MISALIGN;
                state      <= S_DONE;
              end else begin
                res_status <= bfa_pkg::ST_OK;
                state      <= S_ISSUE;
              end
            end
            default: begin
              res_status <= bfa_pkg::ST_OK;
              state      <= S_DONE;
            end
          endcase
        end
        S_ISSUE: begin
          // memory reads at fi this cycle
          state <= S_MODIFY;
        end
        S_MODIFY: begin
          case (cur.command)
            bfa_pkg::CMD_FREE: begin
              if (!bm_rdata[fi_bit]) begin
                res_status <= bfa_pkg::ST_NOT_ALLOC;
              end
            end
            bfa_pkg::CMD_MARK: begin
            end
            default: begin
              res_count <= ref_new;
              if (cur.command == bfa_pkg::CMD_INC && ref_rdata == bfa_pkg::COUNT_MAX) begin
                res_status <= bfa_pkg::ST_OVERFLOW;
              end
            end
          endcase
          state <= S_DONE;
        end
        S_SCAN: begin
          // read of the next word overlaps evaluation of the current one
          scan_word <= scan_word + WORD_AW'(1);
          eval_word <= scan_word;
          eval_vld  <= 1'b1;
          if (eval_vld && hit) begin
            res_addr <= alloc_addr;
            state    <= S_DONE;
          end else if (eval_vld && eval_word == last_word) begin
            res_status <= bfa_pkg::ST_NONE_FREE;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.status         <= res_status;
            rsp.result_address <= res_addr;
            rsp.ref_count      <= res_count;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
